>>> hdl/imu_cf_pkg.sv
// Shared types, constants and tables for the IMU complementary filter.
// No dependencies; every other file of the block depends on this package.
`default_nettype none
package imu_cf_pkg;

  // Field widths
  localparam int ACC_W      = 16;
  localparam int RATE_W     = 16;
  localparam int TICK_W     = 32;
  localparam int DEG_W      = 24;
  localparam int ANG_W      = 32;
  localparam int DT_W       = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DW     = 26;
  localparam int WEIGHT_W   = 17;
  localparam int DRIFT_W    = 26;
  localparam int DTMIN_W    = 10;
  localparam int DTMAX_W    = 16;

  localparam int AVG_DEPTH_DEF = 4;

  // CORDIC
  localparam int CORDIC_ITERS = 24;
  localparam int ITER_W       = 5;
  localparam int ZW           = 28;
  localparam logic signed [ZW-1:0] ANG_HALF_PI = 28'sd26353589;

  // Shared multiplier
  localparam int MUL_AW = 34;
  localparam int MUL_BW = 25;
  localparam int MUL_PW = MUL_AW + MUL_BW;

  localparam logic [MUL_BW-1:0] INV_GAIN_Q24 = 25'd10188014;
  localparam logic [MUL_BW-1:0] GYRO_K_Q16   = 25'd1199381;
  localparam logic [MUL_BW-1:0] DEG_K_Q32    = 25'd3754936;
  localparam logic [WEIGHT_W-1:0] W_ONE      = 17'd65536;

  // Reset values of the registers
  localparam logic [WEIGHT_W-1:0] GYRO_WEIGHT_RST = 17'd16384;
  localparam logic [DRIFT_W-1:0]  DRIFT_LIMIT_RST = 26'd1647099;
  localparam logic [DTMIN_W-1:0]  DT_MIN_RST      = 10'd1;
  localparam logic [DTMAX_W-1:0]  DT_MAX_RST      = 16'd1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GYRO_WEIGHT = 3'd0,
    REG_DRIFT_LIMIT = 3'd1,
    REG_DT_MIN      = 3'd2,
    REG_DT_MAX      = 3'd3
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_C1S,
    ST_C1W,
    ST_MAGM,
    ST_MAGU,
    ST_C2W,
    ST_IRD,
    ST_IK,
    ST_IUPD,
    ST_SNAP,
    ST_BG,
    ST_BA,
    ST_BR,
    ST_DM,
    ST_DU,
    ST_DONE
  } fsm_e;

  // atan(2^-i) in rad * 2^24
  function automatic logic signed [ZW-1:0] atan_entry(input logic [ITER_W-1:0] i);
    logic signed [ZW-1:0] r;
    case (i)
      5'd0:    r = 28'sd13176795;
      5'd1:    r = 28'sd7778716;
      5'd2:    r = 28'sd4110060;
      5'd3:    r = 28'sd2086331;
      5'd4:    r = 28'sd1047214;
      5'd5:    r = 28'sd524117;
      5'd6:    r = 28'sd262123;
      5'd7:    r = 28'sd131069;
      5'd8:    r = 28'sd65536;
      5'd9:    r = 28'sd32768;
      5'd10:   r = 28'sd16384;
      5'd11:   r = 28'sd8192;
      5'd12:   r = 28'sd4096;
      5'd13:   r = 28'sd2048;
      5'd14:   r = 28'sd1024;
      5'd15:   r = 28'sd512;
      5'd16:   r = 28'sd256;
      5'd17:   r = 28'sd128;
      5'd18:   r = 28'sd64;
      5'd19:   r = 28'sd32;
      5'd20:   r = 28'sd16;
      5'd21:   r = 28'sd8;
      5'd22:   r = 28'sd4;
      5'd23:   r = 28'sd2;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> hdl/imu_cf_if.sv
// Valid/ready channel interfaces for IMU samples and attitude results.
// Depends on imu_cf_pkg for field widths.
`default_nettype none
interface imu_cf_in_if;
  import imu_cf_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [ACC_W-1:0]  acc_x;
  logic signed [ACC_W-1:0]  acc_y;
  logic signed [ACC_W-1:0]  acc_z;
  logic signed [RATE_W-1:0] gyro_x;
  logic signed [RATE_W-1:0] gyro_y;
  logic signed [RATE_W-1:0] gyro_z;
  logic [TICK_W-1:0]        tick_ms;
  modport source (output valid, acc_x, acc_y, acc_z, gyro_x, gyro_y, gyro_z, tick_ms,
                  input ready);
  modport sink (input valid, acc_x, acc_y, acc_z, gyro_x, gyro_y, gyro_z, tick_ms,
                output ready);
endinterface

interface imu_cf_out_if;
  import imu_cf_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [DEG_W-1:0] roll_deg;
  logic signed [DEG_W-1:0] pitch_deg;
  logic signed [DEG_W-1:0] yaw_deg;
  modport source (output valid, roll_deg, pitch_deg, yaw_deg, input ready);
  modport sink (input valid, roll_deg, pitch_deg, yaw_deg, output ready);
endinterface
`default_nettype wire

>>> hdl/imu_cf_mul.sv
// Shared signed multiplier with a registered product.
// Depends on imu_cf_pkg for default operand widths.
`default_nettype none
module imu_cf_mul #(
  parameter int AW = imu_cf_pkg::MUL_AW,
  parameter int BW = imu_cf_pkg::MUL_BW
) (
  input  wire logic                 clk_i,
  input  wire logic signed [AW-1:0] a_i,
  input  wire logic signed [BW-1:0] b_i,
  output logic signed [AW+BW-1:0]   p_o
);
  // one product per cycle, ready the cycle after operands are set
  always_ff @(posedge clk_i) begin
    p_o <= (AW+BW)'(a_i) * (AW+BW)'(b_i);
  end
endmodule
`default_nettype wire

>>> hdl/imu_cf_cordic.sv
// Iterative CORDIC vectoring unit: one micro-rotation per cycle.
// Depends on imu_cf_pkg for the arctangent table and angle width.
`default_nettype none
module imu_cf_cordic #(
  parameter int CW = 29
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic signed [CW-1:0] x_i,
  input  wire logic signed [CW-1:0] y_i,
  output logic                      done_o,
  output logic signed [imu_cf_pkg::ZW-1:0] ang_o,
  output logic signed [CW-1:0]      mag_o
);
  import imu_cf_pkg::*;

  logic signed [CW-1:0] x_q, y_q, px, py, dx, dy;
  logic signed [ZW-1:0] z_q, pz, tab;
  logic [ITER_W-1:0]    cnt_q;
  logic                 busy_q, done_q, zero;

  // quadrant pre-rotation into the right half plane
  always_comb begin
    zero = (x_i == '0) && (y_i == '0);
    if (x_i < 0) begin
      if (y_i >= 0) begin
        px = y_i;
        py = -x_i;
        pz = ANG_HALF_PI;
      end else begin
        px = -y_i;
        py = x_i;
        pz = -ANG_HALF_PI;
      end
    end else begin
      px = x_i;
      py = y_i;
      pz = '0;
    end
  end

  // shared shifter and table lookup
  assign dx  = y_q >>> cnt_q;
  assign dy  = x_q >>> cnt_q;
  assign tab = atan_entry(cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      x_q    <= '0;
      y_q    <= '0;
      z_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= '0;
        if (zero) begin
          // zero vector: angle and magnitude are both zero
          x_q    <= '0;
          y_q    <= '0;
          z_q    <= '0;
          done_q <= 1'b1;
        end else begin
          x_q    <= px;
          y_q    <= py;
          z_q    <= pz;
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        if (y_q >= 0) begin
          x_q <= x_q + dx;
          y_q <= y_q - dy;
          z_q <= z_q + tab;
        end else begin
          x_q <= x_q - dx;
          y_q <= y_q + dy;
          z_q <= z_q - tab;
        end
        if (cnt_q == ITER_W'(CORDIC_ITERS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign ang_o  = z_q;
  assign mag_o  = x_q;
endmodule
`default_nettype wire

>>> hdl/imu_complementary_filter_core.sv
// IMU complementary attitude filter. One sample in, one roll/pitch/yaw result out.
// Each sample is worked through in sequenced steps. The two CORDIC passes make up most
// of that work: each runs 24 micro-rotations and then hands back the result, or
// skips the micro-rotations for a zero accel vector. The other
// steps are the idle step that takes the request, the two CORDIC starts, and the steps
// that reuse one shared multiplier (gain correction, three gyro integrations in three
// steps each, a snap step, two blends in three steps each, three degree scalings in
// two steps each, and the step that hands the result to the output register).
// The input is ready only while no sample is in work. A finished result waits in
// an output register, and the next sample is taken while it waits. A sample that
// finishes while the previous result still waits holds in its last step until that
// result is taken.
// Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i; the user must
// do so only while the block is idle, which the block itself does not enforce.
// Depends on imu_cf_pkg, imu_cf_if, imu_cf_mul and imu_cf_cordic.
`default_nettype none
module imu_complementary_filter_core #(
  parameter int AVG_DEPTH = imu_cf_pkg::AVG_DEPTH_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  imu_cf_in_if.sink                               in_i,
  imu_cf_out_if.source                            out_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [imu_cf_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [imu_cf_pkg::CFG_DW-1:0]      cfg_data_i
);
  import imu_cf_pkg::*;

  localparam int SUM_W    = ACC_W + $clog2(AVG_DEPTH);
  localparam int CW       = SUM_W + 11;
  localparam int HIST_LEN = AVG_DEPTH - 1;
  localparam logic signed [MUL_PW-1:0] RND16 = MUL_PW'(1) << 15;
  localparam logic signed [MUL_PW-1:0] RND32 = MUL_PW'(1) << 31;

  fsm_e state_q, state_d;
  logic [1:0] axis_q, axis_d;

  // configuration registers
  logic [WEIGHT_W-1:0] gw_q;
  logic [DRIFT_W-1:0]  drift_q;
  logic [DTMIN_W-1:0]  dtmin_q;
  logic [DTMAX_W-1:0]  dtmax_q;

  // sample state
  logic [TICK_W-1:0]         prev_q;
  logic signed [ACC_W-1:0]   hist_q [3][HIST_LEN];
  logic signed [SUM_W-1:0]   run_q  [3];
  logic signed [SUM_W-1:0]   sum_q  [3];
  logic signed [RATE_W-1:0]  gyro_q [3];
  logic [DT_W-1:0]           dt_q;
  logic signed [ANG_W-1:0]   ang_q  [3];
  logic signed [ZW-1:0]      th_q   [2];
  logic signed [MUL_AW-1:0]  tb_q   [2];
  logic signed [MUL_PW-1:0]  acc_q;
  logic [DEG_W-1:0]          deg_q  [3];
  logic [DEG_W-1:0]          res_q  [3];
  logic                      out_valid_q;

  logic accept;
  logic signed [ACC_W-1:0] smp [3];
  logic [TICK_W-1:0] dt_raw, dt_lo;
  logic [DT_W-1:0]   dt_c;
  logic [WEIGHT_W-1:0] w_eff;

  // shared units
  logic signed [MUL_AW-1:0] mul_a;
  logic signed [MUL_BW-1:0] mul_b;
  logic signed [MUL_PW-1:0] prod;
  logic                     cor_start, cor_done;
  logic signed [CW-1:0]     cor_x, cor_y, cor_mag;
  logic signed [ZW-1:0]     cor_ang;

  imu_cf_mul #(.AW(MUL_AW), .BW(MUL_BW)) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  imu_cf_cordic #(.CW(CW)) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .x_i     (cor_x),
    .y_i     (cor_y),
    .done_o  (cor_done),
    .ang_o   (cor_ang),
    .mag_o   (cor_mag)
  );

  assign accept = in_i.valid && in_i.ready;
  assign smp[0] = in_i.acc_x;
  assign smp[1] = in_i.acc_y;
  assign smp[2] = in_i.acc_z;

  // elapsed time with clamps
  always_comb begin
    dt_raw = in_i.tick_ms - prev_q;
    dt_lo  = (dt_raw < TICK_W'(dtmin_q)) ? TICK_W'(dtmin_q) : dt_raw;
    dt_c   = (dt_lo > TICK_W'(dtmax_q)) ? dtmax_q : dt_lo[DT_W-1:0];
  end

  assign w_eff = (gw_q > W_ONE) ? W_ONE : gw_q;

  // integration, snap and output helpers
  logic signed [MUL_PW-1:0] delta;
  logic signed [MUL_PW:0]   isum;
  logic                     iovf;
  logic signed [ANG_W-1:0]  isat;
  logic signed [MUL_PW-1:0] bsum;
  logic signed [MUL_PW-1:0] drnd;
  logic signed [MUL_AW-1:0] sd   [2];
  logic [MUL_AW-1:0]        sabs [2];
  logic                     snap [2];

  always_comb begin
    delta = (prod + RND16) >>> 16;
    isum  = (MUL_PW+1)'(ang_q[axis_q]) + (MUL_PW+1)'(delta);
    iovf  = !((&isum[MUL_PW:ANG_W-1]) || !(|isum[MUL_PW:ANG_W-1]));
    if (iovf) begin
      isat = isum[MUL_PW] ? {1'b1, {(ANG_W-1){1'b0}}} : {1'b0, {(ANG_W-1){1'b1}}};
    end else begin
      isat = isum[ANG_W-1:0];
    end
    bsum = acc_q + prod + RND16;
    drnd = prod + RND32;
    for (int k = 0; k < 2; k++) begin
      sd[k]   = MUL_AW'(ang_q[k]) - MUL_AW'(th_q[k]);
      sabs[k] = sd[k][MUL_AW-1] ? MUL_AW'(-sd[k]) : MUL_AW'(sd[k]);
      snap[k] = sabs[k] > MUL_AW'(drift_q);
    end
  end

  // sequencer: next state and operand selection
  always_comb begin
    state_d   = state_q;
    axis_d    = axis_q;
    mul_a     = '0;
    mul_b     = '0;
    cor_start = 1'b0;
    cor_x     = CW'(sum_q[2]) <<< 8;
    cor_y     = CW'(sum_q[1]) <<< 8;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_C1S;
      end
      ST_C1S: begin
        cor_start = 1'b1;
        state_d   = ST_C1W;
      end
      ST_C1W: begin
        if (cor_done) state_d = ST_MAGM;
      end
      ST_MAGM: begin
        mul_a   = MUL_AW'(cor_mag);
        mul_b   = INV_GAIN_Q24;
        state_d = ST_MAGU;
      end
      ST_MAGU: begin
        cor_start = 1'b1;
        cor_x     = prod[24+CW-1:24];
        cor_y     = -(CW'(sum_q[0]) <<< 8);
        state_d   = ST_C2W;
      end
      ST_C2W: begin
        if (cor_done) begin
          axis_d  = 2'd0;
          state_d = ST_IRD;
        end
      end
      ST_IRD: begin
        mul_a   = MUL_AW'(gyro_q[axis_q]);
        mul_b   = MUL_BW'(dt_q);
        state_d = ST_IK;
      end
      ST_IK: begin
        mul_a   = prod[MUL_AW-1:0];
        mul_b   = GYRO_K_Q16;
        state_d = ST_IUPD;
      end
      ST_IUPD: begin
        if (axis_q == 2'd2) begin
          state_d = ST_SNAP;
        end else begin
          axis_d  = axis_q + 1'b1;
          state_d = ST_IRD;
        end
      end
      ST_SNAP: begin
        axis_d  = 2'd0;
        state_d = ST_BG;
      end
      ST_BG: begin
        mul_a   = MUL_AW'(ang_q[axis_q[0]]);
        mul_b   = MUL_BW'(w_eff);
        state_d = ST_BA;
      end
      ST_BA: begin
        mul_a   = MUL_AW'(th_q[axis_q[0]]);
        mul_b   = MUL_BW'(W_ONE - w_eff);
        state_d = ST_BR;
      end
      ST_BR: begin
        if (axis_q == 2'd1) begin
          axis_d  = 2'd0;
          state_d = ST_DM;
        end else begin
          axis_d  = axis_q + 1'b1;
          state_d = ST_BG;
        end
      end
      ST_DM: begin
        case (axis_q)
          2'd0:    mul_a = -tb_q[1];
          2'd1:    mul_a = tb_q[0];
          default: mul_a = MUL_AW'(ang_q[2]);
        endcase
        mul_b   = DEG_K_Q32;
        state_d = ST_DU;
      end
      ST_DU: begin
        if (axis_q == 2'd2) begin
          state_d = ST_DONE;
        end else begin
          axis_d  = axis_q + 1'b1;
          state_d = ST_DM;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      axis_q  <= '0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gw_q    <= GYRO_WEIGHT_RST;
      drift_q <= DRIFT_LIMIT_RST;
      dtmin_q <= DT_MIN_RST;
      dtmax_q <= DT_MAX_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_GYRO_WEIGHT: gw_q    <= cfg_data_i[WEIGHT_W-1:0];
        REG_DRIFT_LIMIT: drift_q <= cfg_data_i[DRIFT_W-1:0];
        REG_DT_MIN:      dtmin_q <= cfg_data_i[DTMIN_W-1:0];
        REG_DT_MAX:      dtmax_q <= cfg_data_i[DTMAX_W-1:0];
        default: ;
      endcase
    end
  end

  // filter state: timestamp, accel history with running sums, integrators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      for (int a = 0; a < 3; a++) begin
        run_q[a] <= '0;
        ang_q[a] <= '0;
        for (int h = 0; h < HIST_LEN; h++) hist_q[a][h] <= '0;
      end
    end else begin
      if (accept) begin
        prev_q <= in_i.tick_ms;
        for (int a = 0; a < 3; a++) begin
          run_q[a] <= run_q[a] + SUM_W'(smp[a]) - SUM_W'(hist_q[a][HIST_LEN-1]);
          for (int h = HIST_LEN - 1; h > 0; h--) hist_q[a][h] <= hist_q[a][h-1];
          hist_q[a][0] <= smp[a];
        end
      end
      if (state_q == ST_IUPD) ang_q[axis_q] <= isat;
      if (state_q == ST_SNAP) begin
        for (int k = 0; k < 2; k++) begin
          if (snap[k]) ang_q[k] <= ANG_W'(th_q[k]);
        end
      end
    end
  end

  // per-sample working registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      dt_q      <= dt_c;
      gyro_q[0] <= in_i.gyro_x;
      gyro_q[1] <= in_i.gyro_y;
      gyro_q[2] <= in_i.gyro_z;
      for (int a = 0; a < 3; a++) sum_q[a] <= run_q[a] + SUM_W'(smp[a]);
    end
    if (state_q == ST_C1W && cor_done) th_q[0] <= cor_ang;
    if (state_q == ST_C2W && cor_done) th_q[1] <= cor_ang;
    if (state_q == ST_BA) acc_q <= prod;
    if (state_q == ST_BR) tb_q[axis_q[0]] <= bsum[16+MUL_AW-1:16];
    if (state_q == ST_DU) deg_q[axis_q] <= drnd[32+DEG_W-1:32];
    if (state_q == ST_DONE && (!out_valid_q || out_o.ready)) begin
      for (int a = 0; a < 3; a++) res_q[a] <= deg_q[a];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_DONE && (!out_valid_q || out_o.ready)) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign in_i.ready      = (state_q == ST_IDLE);
  assign out_o.valid     = out_valid_q;
  assign out_o.roll_deg  = res_q[0];
  assign out_o.pitch_deg = res_q[1];
  assign out_o.yaw_deg   = res_q[2];

  // CORDIC finishes only while the sequencer waits for it
  a_cordic_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cor_done |-> (state_q == ST_C1W || state_q == ST_C2W))
    else $error("CORDIC result outside a wait state");

  // yaw integrator moves only in the integration update step
  a_yaw_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IUPD) |=> $stable(ang_q[2]))
    else $error("yaw integrator changed outside update");

  // a new result appears only when a sample completes
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_DONE)
    else $error("result valid without a finished sample");

endmodule
`default_nettype wire
